@@ design/ttqm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttqm_pkg
// Shared types, widths, register indexes and reset values for the touch tap
// qualifier and mapper.
// ----------------------------------------------------------------------------
package ttqm_pkg;

    // Field widths of the channels.
    localparam int PANEL_W   = 12;
    localparam int SCR_W     = 11;
    localparam int STAMP_W   = 32;
    localparam int HOLD_W    = 16;

    // Effective bits of raw samples and timestamps.
    localparam int RAW_BITS  = 12;
    localparam int TIME_BITS = 32;
    localparam logic [PANEL_W-1:0] RAW_MASK = PANEL_W'((64'd1 << RAW_BITS) - 64'd1);

    // Configuration port.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // Divider sizing: numerator is (clamped - min) * screen_last, two
    // quotient bits are resolved per cycle.
    localparam int NUM_W     = PANEL_W + SCR_W;
    localparam int DIV_STEPS = (NUM_W + 1) / 2;
    localparam int DIV_W     = 2 * DIV_STEPS;
    localparam int REM_W     = PANEL_W + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_X_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_X_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_Y_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_Y_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_X_LAST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_Y_LAST   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_HOLD_MS = 3'd6;

    // Register reset values.
    localparam logic [PANEL_W-1:0] RST_PANEL_MIN     = 12'd0;
    localparam logic [PANEL_W-1:0] RST_PANEL_MAX     = 12'd4095;
    localparam logic [SCR_W-1:0]   RST_SCREEN_X_LAST = 11'd319;
    localparam logic [SCR_W-1:0]   RST_SCREEN_Y_LAST = 11'd239;
    localparam logic [HOLD_W-1:0]  RST_RELEASE_HOLD  = 16'd50;

    // Axis codes: screen X comes from panel Y, screen Y from panel X.
    localparam logic AXIS_SCREEN_X = 1'b0;
    localparam logic AXIS_SCREEN_Y = 1'b1;

    // One poll of the panel.
    typedef struct packed {
        logic               touch_active;
        logic [STAMP_W-1:0] now_ms;
        logic               sample_ok;
        logic [PANEL_W-1:0] panel_x;
        logic [PANEL_W-1:0] panel_y;
        logic [PANEL_W-1:0] panel_pressure;
    } t_in_item;

    // One result of a poll.
    typedef struct packed {
        logic               active_out;
        logic               tap_event;
        logic [SCR_W-1:0]   screen_x;
        logic [SCR_W-1:0]   screen_y;
        logic [PANEL_W-1:0] tap_pressure;
        logic [PANEL_W-1:0] tap_raw_x;
        logic [PANEL_W-1:0] tap_raw_y;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic prep;
        logic div_step;
        logic save;
        logic load_out;
        logic axis;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tap;
    } t_sts;

endpackage

@@ design/ttqm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttqm_ctrl
// Sequencer: takes an item, runs both axes through the shared divider when a
// tap is raised, and hands the result to the output register.
// ----------------------------------------------------------------------------
module ttqm_ctrl
    import ttqm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_DIV  = 5'b00100,
        S_SAVE = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic             r_axis, n_axis;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    // The output register may be loaded when empty or drained this cycle.
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        n_axis        = r_axis;
        n_cnt         = r_cnt;
        o_cmd         = '0;
        o_cmd.axis    = r_axis;
        n_out_valid   = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_axis        = AXIS_SCREEN_X;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                if (i_sts.tap) begin
                    o_cmd.prep = 1'b1;
                    n_cnt      = CNT_W'(DIV_STEPS - 1);
                    n_state    = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_SAVE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_SAVE: begin
                o_cmd.save = 1'b1;
                if (r_axis == AXIS_SCREEN_X) begin
                    n_axis  = AXIS_SCREEN_Y;
                    n_state = S_PREP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= AXIS_SCREEN_X;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ design/ttqm_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttqm_dp
// Datapath: configuration registers, tap qualification and release timing,
// clamp and scale of one axis, shared radix-4 restoring divider, and the
// output register.
// ----------------------------------------------------------------------------
module ttqm_dp
    import ttqm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  t_in_item             i_in_item,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output t_out_item            o_out_item
);

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] num;
    } t_div;

    // Configuration registers.
    logic [PANEL_W-1:0] r_x_min, r_x_max, r_y_min, r_y_max;
    logic [SCR_W-1:0]   r_sx_last, r_sy_last;
    logic [HOLD_W-1:0]  r_hold;

    // Qualifier state.
    logic                 r_sent;
    logic                 r_timing;
    logic [TIME_BITS-1:0] r_start;
    logic                 r_tap;

    // Item and arithmetic registers.
    t_in_item           r_item;
    logic [PANEL_W-1:0] r_den;
    logic               r_zero;
    t_div               r_div;
    logic [SCR_W-1:0]   r_sx, r_sy;
    t_out_item          r_out;

    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_elapsed;
    logic [PANEL_W-1:0]   w_raw, w_lo, w_hi, w_clamp, w_diff;
    logic [SCR_W-1:0]     w_last;
    logic [NUM_W-1:0]     w_prod;
    t_div                 w_div_a, w_div_b;
    logic [SCR_W-1:0]     w_quot;

    // One restoring division step: shift in one numerator bit, subtract if
    // the partial remainder reaches the divisor.
    function automatic t_div div_bit(input t_div d, input logic [PANEL_W-1:0] den);
        logic [REM_W-1:0] t;
        logic             q;
        t_div             r;
        t = {d.rem[PANEL_W-1:0], d.num[DIV_W-1]};
        q = (t >= {1'b0, den});
        r.rem = q ? (t - {1'b0, den}) : t;
        r.num = {d.num[DIV_W-2:0], q};
        return r;
    endfunction

    assign o_sts.tap  = r_tap;
    assign o_out_item = r_out;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min   <= RST_PANEL_MIN;
            r_x_max   <= RST_PANEL_MAX;
            r_y_min   <= RST_PANEL_MIN;
            r_y_max   <= RST_PANEL_MAX;
            r_sx_last <= RST_SCREEN_X_LAST;
            r_sy_last <= RST_SCREEN_Y_LAST;
            r_hold    <= RST_RELEASE_HOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PANEL_X_MIN:     r_x_min   <= i_cfg_wdata[PANEL_W-1:0];
                REG_PANEL_X_MAX:     r_x_max   <= i_cfg_wdata[PANEL_W-1:0];
                REG_PANEL_Y_MIN:     r_y_min   <= i_cfg_wdata[PANEL_W-1:0];
                REG_PANEL_Y_MAX:     r_y_max   <= i_cfg_wdata[PANEL_W-1:0];
                REG_SCREEN_X_LAST:   r_sx_last <= i_cfg_wdata[SCR_W-1:0];
                REG_SCREEN_Y_LAST:   r_sy_last <= i_cfg_wdata[SCR_W-1:0];
                REG_RELEASE_HOLD_MS: r_hold    <= i_cfg_wdata[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Elapsed release time, wrapping in the timestamp width.
    assign w_now     = i_in_item.now_ms[TIME_BITS-1:0];
    assign w_elapsed = w_now - r_start;

    // Tap qualification and release debounce, decided when an item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent   <= 1'b0;
            r_timing <= 1'b0;
            r_start  <= '0;
            r_tap    <= 1'b0;
        end else if (i_cmd.load_in) begin
            r_tap <= 1'b0;
            if (i_in_item.touch_active) begin
                r_timing <= 1'b0;
                if (!r_sent && i_in_item.sample_ok) begin
                    r_sent <= 1'b1;
                    r_tap  <= 1'b1;
                end
            end else if (r_sent) begin
                if (!r_timing) begin
                    r_timing <= 1'b1;
                    r_start  <= w_now;
                end else if (w_elapsed >= TIME_BITS'(r_hold)) begin
                    r_sent   <= 1'b0;
                    r_timing <= 1'b0;
                end
            end
        end
    end

    // Operand selection and clamp for the axis being worked on.
    always_comb begin
        if (i_cmd.axis == AXIS_SCREEN_X) begin
            w_raw  = r_item.panel_y & RAW_MASK;
            w_lo   = r_y_min;
            w_hi   = r_y_max;
            w_last = r_sx_last;
        end else begin
            w_raw  = r_item.panel_x & RAW_MASK;
            w_lo   = r_x_min;
            w_hi   = r_x_max;
            w_last = r_sy_last;
        end
        if (w_raw < w_lo) begin
            w_clamp = w_lo;
        end else if (w_raw > w_hi) begin
            w_clamp = w_hi;
        end else begin
            w_clamp = w_raw;
        end
        w_diff = w_clamp - w_lo;
        w_prod = NUM_W'(w_diff) * NUM_W'(w_last);
    end

    // Two quotient bits per cycle.
    assign w_div_a = div_bit(r_div, r_den);
    assign w_div_b = div_bit(w_div_a, r_den);

    // The quotient never exceeds screen_last; a zero or inverted span maps to 0.
    assign w_quot = r_zero ? '0 : r_div.num[SCR_W-1:0];

    // Item latch, divider and per-axis results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_item <= i_in_item;
        end
        if (i_cmd.prep) begin
            r_den     <= w_hi - w_lo;
            r_zero    <= (w_hi <= w_lo);
            r_div.rem <= '0;
            r_div.num <= DIV_W'(w_prod);
        end else if (i_cmd.div_step) begin
            r_div <= w_div_b;
        end
        if (i_cmd.save) begin
            if (i_cmd.axis == AXIS_SCREEN_X) begin
                r_sx <= w_quot;
            end else begin
                r_sy <= w_quot;
            end
        end
    end

    // Output register; fields other than the activity echo are zero without a tap.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.active_out <= r_item.touch_active;
            r_out.tap_event  <= r_tap;
            if (r_tap) begin
                r_out.screen_x     <= r_sx;
                r_out.screen_y     <= r_sy;
                r_out.tap_pressure <= r_item.panel_pressure & RAW_MASK;
                r_out.tap_raw_x    <= r_item.panel_x & RAW_MASK;
                r_out.tap_raw_y    <= r_item.panel_y & RAW_MASK;
            end else begin
                r_out.screen_x     <= '0;
                r_out.screen_y     <= '0;
                r_out.tap_pressure <= '0;
                r_out.tap_raw_x    <= '0;
                r_out.tap_raw_y    <= '0;
            end
        end
    end

endmodule

@@ design/touch_tap_qualifier_mapper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_tap_qualifier_mapper
// Qualifies one tap per touch and maps its raw panel position to screen
// coordinates through calibration registers.
//
//   Port group   Handshake               Payload
//   input item   i_in_valid/o_in_ready   i_in_item  (t_in_item)
//   result item  o_out_valid/i_out_ready o_out_item (t_out_item)
//   config       i_cfg_we                i_cfg_idx, i_cfg_wdata
//
// A poll that raises a tap passes both axes one after the other through a
// shared divider that resolves two quotient bits per cycle, with a setup
// and a save step per axis around the divide steps. Other polls skip the
// divider. The input is ready again in the cycle after the result is
// loaded, so a new item is taken only once the last one's result is loaded.
// Reset is synchronous and active low and restores the register defaults.
// A stalled result waits in the output register; the next item is accepted
// meanwhile and its result is held until that register frees.
// ----------------------------------------------------------------------------
module touch_tap_qualifier_mapper
    import ttqm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    ttqm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath.
    ttqm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_item  (o_out_item)
    );

endmodule

@@ verif/touch_tap_qualifier_mapper_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_tap_qualifier_mapper_tb
// Self-checking bench for the touch tap qualifier and mapper. Polls are sent
// through the input handshake while the result side stalls at random. Each
// accepted poll is run through a local tap qualifier and axis mapper, and
// every result item is compared field by field with the oldest prediction.
// Directed polls cover the calibration and timing corners, and random touch
// episodes run under several register settings.
// ----------------------------------------------------------------------------
module touch_tap_qualifier_mapper_tb;
    import ttqm_pkg::*;

    // Index past the end of the register file; writes to it are dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // Clock, reset and the block's inputs, all known from time zero.
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 poll_valid = 1'b0;
    t_in_item             poll_item = '0;
    logic                 result_ready = 1'b0;

    logic                 o_in_ready;
    logic                 o_out_valid;
    t_out_item            o_out_item;

    // Local copy of the calibration registers.
    logic [PANEL_W-1:0]   cal_x_min = RST_PANEL_MIN;
    logic [PANEL_W-1:0]   cal_x_max = RST_PANEL_MAX;
    logic [PANEL_W-1:0]   cal_y_min = RST_PANEL_MIN;
    logic [PANEL_W-1:0]   cal_y_max = RST_PANEL_MAX;
    logic [SCR_W-1:0]     cal_sx_last = RST_SCREEN_X_LAST;
    logic [SCR_W-1:0]     cal_sy_last = RST_SCREEN_Y_LAST;
    logic [HOLD_W-1:0]    cal_hold = RST_RELEASE_HOLD;

    // Local copy of the tap state.
    logic                 tap_delivered = 1'b0;
    logic                 timing_release = 1'b0;
    logic [STAMP_W-1:0]   release_stamp = '0;

    t_out_item            pending_results[$];
    int                   mismatches = 0;
    logic [STAMP_W-1:0]   stamp_ms = 32'd0;
    bit                   steady = 1'b0;

    touch_tap_qualifier_mapper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (poll_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (poll_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (result_ready),
        .o_out_item  (o_out_item)
    );

    always #4 i_clk = ~i_clk;

    // Clamp a raw reading into the calibration window and scale it.
    function automatic logic [SCR_W-1:0] map_axis(input logic [PANEL_W-1:0] raw,
                                                  input logic [PANEL_W-1:0] lo,
                                                  input logic [PANEL_W-1:0] hi,
                                                  input logic [SCR_W-1:0] last);
        logic [PANEL_W-1:0]       clamped;
        logic [NUM_W-1:0]         product;
        logic [NUM_W-1:0]         quotient;
        if (hi <= lo) begin
            return '0;
        end
        clamped  = (raw < lo) ? lo : ((raw > hi) ? hi : raw);
        product  = NUM_W'(clamped - lo) * NUM_W'(last);
        quotient = product / NUM_W'(hi - lo);
        return quotient[SCR_W-1:0];
    endfunction

    // Qualify one poll against the tap state and build its result.
    task automatic qualify_poll(input t_in_item p, output t_out_item r);
        logic [STAMP_W-1:0] elapsed;
        logic [PANEL_W-1:0] rx;
        logic [PANEL_W-1:0] ry;
        r  = '0;
        rx = p.panel_x & RAW_MASK;
        ry = p.panel_y & RAW_MASK;
        r.active_out = p.touch_active;
        if (p.touch_active) begin
            timing_release = 1'b0;
            if (!tap_delivered && p.sample_ok) begin
                tap_delivered  = 1'b1;
                r.tap_event    = 1'b1;
                r.screen_x     = map_axis(ry, cal_y_min, cal_y_max, cal_sx_last);
                r.screen_y     = map_axis(rx, cal_x_min, cal_x_max, cal_sy_last);
                r.tap_pressure = p.panel_pressure & RAW_MASK;
                r.tap_raw_x    = rx;
                r.tap_raw_y    = ry;
            end
        end else if (tap_delivered) begin
            elapsed = p.now_ms - release_stamp;
            if (!timing_release) begin
                timing_release = 1'b1;
                release_stamp  = p.now_ms;
            end else if (elapsed >= STAMP_W'(cal_hold)) begin
                tap_delivered  = 1'b0;
                timing_release = 1'b0;
            end
        end
    endtask

    // Send one poll, idling at random first; valid stays high afterwards.
    task automatic send_poll(input t_in_item p);
        t_out_item r;
        if (!steady && $urandom_range(99) < 28) begin
            poll_valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < 28);
        end
        poll_valid <= 1'b1;
        poll_item  <= p;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        qualify_poll(p, r);
        pending_results.push_back(r);
    endtask

    // Drop valid and wait until every predicted result has been seen.
    task automatic drain;
        poll_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_in_item make_poll(input bit active, input bit ok,
                                           input logic [STAMP_W-1:0] stamp,
                                           input logic [PANEL_W-1:0] x,
                                           input logic [PANEL_W-1:0] y,
                                           input logic [PANEL_W-1:0] pressure);
        t_in_item p;
        p.touch_active   = active;
        p.now_ms         = stamp;
        p.sample_ok      = ok;
        p.panel_x        = x;
        p.panel_y        = y;
        p.panel_pressure = pressure;
        return p;
    endfunction

    function automatic t_in_item noise_poll;
        return make_poll(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                         PANEL_W'($urandom), PANEL_W'($urandom), PANEL_W'($urandom));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // Write all registers, with junk in the unused upper bits, then the
    // unused index. Only called while the block is idle.
    task automatic set_config(input logic [PANEL_W-1:0] xmin, input logic [PANEL_W-1:0] xmax,
                              input logic [PANEL_W-1:0] ymin, input logic [PANEL_W-1:0] ymax,
                              input logic [SCR_W-1:0] sxl, input logic [SCR_W-1:0] syl,
                              input logic [HOLD_W-1:0] hold);
        logic [CFG_W-1:0] junk;
        junk = CFG_W'($urandom);
        write_reg(REG_PANEL_X_MIN,     {junk[15:12], xmin});
        write_reg(REG_PANEL_X_MAX,     {junk[11:8],  xmax});
        write_reg(REG_PANEL_Y_MIN,     {junk[7:4],   ymin});
        write_reg(REG_PANEL_Y_MAX,     {junk[3:0],   ymax});
        write_reg(REG_SCREEN_X_LAST,   {junk[15:11], sxl});
        write_reg(REG_SCREEN_Y_LAST,   {junk[4:0],   syl});
        write_reg(REG_RELEASE_HOLD_MS, hold);
        write_reg(REG_UNUSED,          CFG_W'($urandom));
        cfg_we      <= 1'b0;
        cal_x_min   = xmin;
        cal_x_max   = xmax;
        cal_y_min   = ymin;
        cal_y_max   = ymax;
        cal_sx_last = sxl;
        cal_sy_last = syl;
        cal_hold    = hold;
    endtask

    // Pick a setting; a wild one may have inverted spans and long holds.
    task automatic random_config(input bit wild);
        if (wild) begin
            set_config(PANEL_W'($urandom), PANEL_W'($urandom),
                       PANEL_W'($urandom), PANEL_W'($urandom),
                       SCR_W'($urandom), SCR_W'($urandom), HOLD_W'($urandom));
        end else begin
            set_config(PANEL_W'($urandom_range(0, 1200)), PANEL_W'($urandom_range(2800, 4095)),
                       PANEL_W'($urandom_range(0, 1200)), PANEL_W'($urandom_range(2800, 4095)),
                       SCR_W'($urandom_range(0, 2047)), SCR_W'($urandom_range(0, 2047)),
                       HOLD_W'($urandom_range(0, 120)));
        end
    endtask

    // Move the poll clock on; sometimes by a large jump so long holds expire.
    task automatic advance_stamp;
        if ($urandom_range(99) < 10) begin
            stamp_ms = stamp_ms + $urandom;
        end else begin
            stamp_ms = stamp_ms + $urandom_range(0, cal_hold / 2 + 5);
        end
    endtask

    // Defaults after reset: one tap per touch, debounce at exactly the hold.
    task automatic test_reset_defaults;
        send_poll(make_poll(1, 0, 1000, 12'd7, 12'd9, 12'd11));
        send_poll(make_poll(1, 1, 1001, 12'd0, 12'd4095, 12'd4095));
        send_poll(make_poll(1, 1, 1002, 12'd4095, 12'd0, 12'd1));
        send_poll(make_poll(0, 1, 1010, 12'd5, 12'd5, 12'd5));
        // An active poll cancels release timing.
        send_poll(make_poll(1, 0, 1020, 12'd5, 12'd5, 12'd5));
        send_poll(make_poll(0, 0, 1030, 12'd5, 12'd5, 12'd5));
        send_poll(make_poll(0, 0, 1079, 12'd5, 12'd5, 12'd5));
        send_poll(make_poll(0, 0, 1080, 12'd5, 12'd5, 12'd5));
        // Released with nothing delivered leaves the state alone.
        send_poll(make_poll(0, 1, 1081, 12'd5, 12'd5, 12'd5));
        send_poll(make_poll(1, 1, 1090, 12'd4095, 12'd0, 12'd0));
        drain();
    endtask

    // Clamping below and above the window, a zero span and a zero hold.
    task automatic test_clamp_and_zero_span;
        set_config(12'd100, 12'd3000, 12'd3000, 12'd3000, 11'd2047, 11'd2047, 16'd0);
        send_poll(make_poll(1, 1, 2000, 12'd50, 12'd1234, 12'd2048));
        send_poll(make_poll(0, 0, 2001, 12'd0, 12'd0, 12'd0));
        send_poll(make_poll(0, 0, 2001, 12'd0, 12'd0, 12'd0));
        send_poll(make_poll(1, 1, 2002, 12'd4000, 12'd4000, 12'd100));
        send_poll(make_poll(0, 0, 2003, 12'd0, 12'd0, 12'd0));
        drain();
    endtask

    // Inverted span, the longest hold and a timestamp that wraps.
    task automatic test_inverted_span_and_wrap;
        set_config(12'd4095, 12'd0, 12'd0, 12'd4095, 11'd0, 11'd2047, 16'hFFFF);
        send_poll(make_poll(1, 1, 32'hFFFF_FFF0, 12'd2000, 12'd4095, 12'd77));
        send_poll(make_poll(0, 1, 32'hFFFF_FFF0, 12'd0, 12'd0, 12'd0));
        send_poll(make_poll(0, 1, 32'h0000_FFEE, 12'd0, 12'd0, 12'd0));
        send_poll(make_poll(0, 1, 32'h0000_FFEF, 12'd0, 12'd0, 12'd0));
        send_poll(make_poll(1, 1, 32'hFFFF_FFFF, 12'd4095, 12'd4095, 12'd4095));
        drain();
    endtask

    // Full window onto the largest screen.
    task automatic test_full_scale;
        set_config(12'd0, 12'd4095, 12'd0, 12'd4095, 11'd2047, 11'd2047, 16'd1);
        send_poll(make_poll(0, 0, 5, 12'd0, 12'd0, 12'd0));
        send_poll(make_poll(0, 0, 6, 12'd0, 12'd0, 12'd0));
        send_poll(make_poll(1, 1, 7, 12'd4095, 12'd4095, 12'd2730));
        drain();
    endtask

    // Random touch episodes with noise polls mixed in.
    task automatic test_random_episodes(input int n_items, input bit pause_midway);
        int       sent;
        int       k;
        bit       pause_due;
        t_in_item p;
        sent      = 0;
        pause_due = pause_midway;
        while (sent < n_items) begin
            if ($urandom_range(99) < 15) begin
                send_poll(noise_poll());
                sent++;
            end else begin
                k = $urandom_range(1, 4);
                repeat (k) begin
                    p = noise_poll();
                    p.touch_active = 1'b1;
                    p.sample_ok    = ($urandom_range(99) < 80);
                    p.now_ms       = stamp_ms;
                    send_poll(p);
                    stamp_ms = stamp_ms + $urandom_range(0, 20);
                    sent++;
                end
                k = $urandom_range(1, 5);
                repeat (k) begin
                    p = noise_poll();
                    p.touch_active = 1'b0;
                    p.now_ms       = stamp_ms;
                    send_poll(p);
                    advance_stamp();
                    sent++;
                end
            end
            // Let the block run dry once before carrying on.
            if (pause_due && sent >= n_items / 2) begin
                pause_due = 1'b0;
                drain();
            end
        end
        drain();
    endtask

    // Result side: stall at random except during the steady stretch.
    always @(posedge i_clk) begin
        result_ready <= steady || ($urandom_range(99) >= 28);
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Compare each accepted result item with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && result_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no prediction pending");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("active_out",   want.active_out,   o_out_item.active_out);
                check_field("tap_event",    want.tap_event,    o_out_item.tap_event);
                check_field("screen_x",     want.screen_x,     o_out_item.screen_x);
                check_field("screen_y",     want.screen_y,     o_out_item.screen_y);
                check_field("tap_pressure", want.tap_pressure, o_out_item.tap_pressure);
                check_field("tap_raw_x",    want.tap_raw_x,    o_out_item.tap_raw_x);
                check_field("tap_raw_y",    want.tap_raw_y,    o_out_item.tap_raw_y);
            end
        end
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("touch_tap_qualifier_mapper regression: fail");
        $finish;
    end

    // Test sequence.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_clamp_and_zero_span();
        test_inverted_span_and_wrap();
        test_full_scale();

        stamp_ms = $urandom;
        random_config(1'b0);
        test_random_episodes(100, 1'b0);
        steady = 1'b1;
        random_config(1'b0);
        test_random_episodes(100, 1'b0);
        steady = 1'b0;
        random_config(1'b0);
        test_random_episodes(100, 1'b1);
        set_config(12'd0, 12'd4095, 12'd0, 12'd4095, 11'd2047, 11'd2047, 16'd0);
        test_random_episodes(100, 1'b0);
        random_config(1'b1);
        test_random_episodes(100, 1'b0);

        drain();
        repeat (40) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_results.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("touch_tap_qualifier_mapper regression: pass");
        end else begin
            $display("touch_tap_qualifier_mapper regression: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/ttqm_pkg.sv
design/ttqm_ctrl.sv
design/ttqm_dp.sv
design/touch_tap_qualifier_mapper.sv
verif/touch_tap_qualifier_mapper_tb.sv
